>>> hw/rtl/tdse_pkg.sv
package tdse_pkg;

	localparam int KEY_COUNT = 4;
	localparam int DIGIT_W = 4;
	localparam int TIMER_W = 16;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 16;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
	localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 4'd0;
	localparam logic [TIMER_W-1:0] BLINK_RESET = 16'd300;
	localparam logic [TIMER_W-1:0] ELAPSED_MAX = 16'hFFFF;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [TIMER_W-1:0] timer_t;

	// active-low key levels, set key in bit 0
	typedef struct packed {
		logic shift_key;
		logic down_key;
		logic up_key;
		logic set_key;
	} keys_t;

	typedef struct packed {
		logic       blink_lit;
		logic [1:0] selected_digit;
		logic       editing;
		digit_t     units_digit;
		digit_t     tens_digit;
		digit_t     hundreds_digit;
	} result_t;

	function automatic digit_t digit_inc(input digit_t d);
		digit_inc = (d >= DIGIT_MAX) ? DIGIT_ZERO : d + 4'd1;
	endfunction

	function automatic digit_t digit_dec(input digit_t d);
		digit_dec = (d == DIGIT_ZERO || d > DIGIT_MAX) ? DIGIT_MAX : d - 4'd1;
	endfunction

endpackage

>>> hw/rtl/tdse_input_stage.sv
module tdse_input_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  tdse_pkg::keys_t keys,
	input  logic           take,
	output logic           valid_s1,
	output tdse_pkg::keys_t keys_s1
);
	import tdse_pkg::*;

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			keys_s1 <= keys;
		end
	end

endmodule

>>> hw/rtl/tdse_core.sv
module tdse_core #(
	parameter int NUM_DIGITS = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  tdse_pkg::keys_t  keys_s1,
	input  tdse_pkg::timer_t toggle_ticks,
	output logic             take,
	output logic             out_valid,
	input  logic             out_ready,
	output tdse_pkg::result_t result_s2
);
	import tdse_pkg::*;

	localparam int SEL_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(NUM_DIGITS - 1);

	logic             edit_q, edit_n;
	logic [SEL_W-1:0] sel_q, sel_n;
	digit_t           digits_q [NUM_DIGITS];
	digit_t           digits_n [NUM_DIGITS];
	logic             phase_q, phase_n;
	timer_t           elapsed_q, elapsed_n;
	keys_t            prev_q;
	keys_t            pressed;
	digit_t           cur_digit;
	digit_t           shown [3];
	result_t          result_n;

	assign take = valid_s1 && (!out_valid || out_ready);
	assign pressed = keys_t'(prev_q & ~keys_s1);

	always_comb begin
		edit_n = edit_q;
		sel_n = sel_q;
		digits_n = digits_q;
		phase_n = phase_q;
		elapsed_n = elapsed_q;
		cur_digit = DIGIT_ZERO;
		if (pressed.set_key) begin
			if (!edit_q) begin
				edit_n = 1'b1;
				sel_n = SEL_LAST;
				phase_n = 1'b1;
				elapsed_n = '0;
			end else begin
				edit_n = 1'b0;
				phase_n = 1'b1;
			end
		end
		if (edit_n) begin
			cur_digit = digits_n[sel_n];
			if (pressed.up_key) begin
				cur_digit = digit_inc(cur_digit);
			end
			if (pressed.down_key) begin
				cur_digit = digit_dec(cur_digit);
			end
			digits_n[sel_n] = cur_digit;
			if (pressed.shift_key) begin
				sel_n = (sel_n == '0) ? SEL_LAST : sel_n - SEL_W'(1);
				phase_n = 1'b1;
				elapsed_n = '0;
			end
			if (elapsed_n >= toggle_ticks) begin
				phase_n = !phase_n;
				elapsed_n = '0;
			end else if (elapsed_n != ELAPSED_MAX) begin
				elapsed_n = elapsed_n + 16'd1;
			end
		end
	end

	// missing leading digits read as zero
	for (genvar k = 0; k < 3; k++) begin : g_shown
		if (NUM_DIGITS - 3 + k >= 0) begin : g_have
			assign shown[k] = digits_n[NUM_DIGITS - 3 + k];
		end else begin : g_none
			assign shown[k] = DIGIT_ZERO;
		end
	end

	always_comb begin
		result_n.hundreds_digit = shown[0];
		result_n.tens_digit = shown[1];
		result_n.units_digit = shown[2];
		result_n.editing = edit_n;
		result_n.selected_digit = 2'(sel_n);
		result_n.blink_lit = phase_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edit_q <= 1'b0;
			sel_q <= SEL_LAST;
			phase_q <= 1'b1;
			elapsed_q <= '0;
			prev_q <= '1;
			out_valid <= 1'b0;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				digits_q[i] <= DIGIT_ZERO;
			end
		end else begin
			if (take) begin
				edit_q <= edit_n;
				sel_q <= sel_n;
				phase_q <= phase_n;
				elapsed_q <= elapsed_n;
				prev_q <= keys_s1;
				digits_q <= digits_n;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_s2 <= result_n;
		end
	end

endmodule

>>> hw/rtl/three_digit_setpoint_editor.sv
// Setpoint editor for a small decimal display, one transaction per millisecond tick. Each
// input transaction carries four debounced active-low key levels; a key counts as pressed
// when its level falls. SET toggles edit mode, and in edit mode UP and DOWN step the
// selected digit modulo 10 without carry while SHIFT moves the selection units, tens,
// hundreds, units. The blink phase toggles every cfg_data + 1 ticks while editing. Every input
// transaction yields exactly one output transaction with the digits, mode, selection and
// blink phase after that tick. The block takes one transaction per clock unless the result
// stalls; an input passes the input register, then the result register that also holds the
// editor state. cfg_ready is always high; write the interval only while the block is idle.
module three_digit_setpoint_editor #(
	parameter int NUM_DIGITS = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// set, up, down, shift levels, then zero fill
	input  logic [tdse_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// hundreds[3:0], tens[7:4], units[11:8], editing, selected digit[14:13], blink lit
	output logic [tdse_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [15:0]                          cfg_data
);
	import tdse_pkg::*;

	timer_t  interval_q;
	logic    valid_s1;
	keys_t   keys_s1;
	logic    take;
	result_t result_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= BLINK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			interval_q <= cfg_data;
		end
	end

	tdse_input_stage u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.keys     (keys_t'(s_tdata[KEY_COUNT-1:0])),
		.take     (take),
		.valid_s1 (valid_s1),
		.keys_s1  (keys_s1)
	);

	tdse_core #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.keys_s1      (keys_s1),
		.toggle_ticks (interval_q),
		.take         (take),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.result_s2    (result_s2)
	);

	assign m_tdata = OUT_TDATA_W'(result_s2);

	// back pressure only comes from a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a stalled result");

	// blink is always lit outside edit mode
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !result_s2.editing |-> result_s2.blink_lit)
		else $error("blink dark in normal mode");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> result_s2.units_digit <= DIGIT_MAX && result_s2.tens_digit <= DIGIT_MAX
			&& result_s2.hundreds_digit <= DIGIT_MAX)
		else $error("digit out of decimal range");

	// a press of set flips the mode in the result of that tick
	assert property (@(posedge clk) disable iff (!arst_n)
		take && (keys_s1.set_key == 1'b0) && $past(take) && ($past(keys_s1.set_key) == 1'b1)
		|=> result_s2.editing != $past(result_s2.editing))
		else $error("set press did not toggle mode");

endmodule
